@@ hw/rtl/i2a_pkg.sv @@
`default_nettype none

package i2a_pkg;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [3:0] TOP_POS     = 4'd9;
    localparam int         POW_W       = 34;

    // Sign and magnitude of one number waiting for conversion
    typedef struct packed {
        logic        neg;
        logic [31:0] mag;
    } t_work;

    // One character leaving the block
    typedef struct packed {
        logic [7:0] ascii_char;
        logic       is_last;
        logic [3:0] total_chars;
    } t_char;

    function automatic logic [POW_W-1:0] pow10(input logic [3:0] pos);
        logic [POW_W-1:0] p;
        case (pos)
            4'd0:    p = 34'd1;
            4'd1:    p = 34'd10;
            4'd2:    p = 34'd100;
            4'd3:    p = 34'd1000;
            4'd4:    p = 34'd10000;
            4'd5:    p = 34'd100000;
            4'd6:    p = 34'd1000000;
            4'd7:    p = 34'd10000000;
            4'd8:    p = 34'd100000000;
            4'd9:    p = 34'd1000000000;
            default: p = 34'd0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/i2a_fifo.sv @@
`default_nettype none

module i2a_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (wr_en) begin
            n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
        end
        if (rd_en) begin
            n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/i2a_front.sv @@
`default_nettype none

module i2a_front (
    input  wire logic [31:0] i_value,
    input  wire logic        i_push,
    input  wire logic        i_q_full,
    output logic             o_q_push,
    output i2a_pkg::t_work   o_work,
    output logic             o_full
);

    // Split into sign and unsigned magnitude; the most negative value wraps to 2^31
    always_comb begin
        o_work.neg = i_value[31];
        o_work.mag = i_value[31] ? (~i_value + 32'd1) : i_value;
    end

    assign o_q_push = i_push && !i_q_full;
    assign o_full   = i_q_full;

endmodule

`default_nettype wire

@@ hw/rtl/i2a_back.sv @@
`default_nettype none

module i2a_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire i2a_pkg::t_work i_work,
    input  wire logic          i_work_empty,
    output logic               o_work_pop,
    input  wire logic          i_out_full,
    output logic               o_out_push,
    output i2a_pkg::t_char     o_char
);

    localparam int PW = i2a_pkg::POW_W;

    logic        r_busy, n_busy;
    logic        r_sign, n_sign;
    logic        r_started, n_started;
    logic [3:0]  r_pos, n_pos;
    logic [3:0]  r_cnt, n_cnt;
    logic [31:0] r_rem, n_rem;

    logic [PW-1:0] pw;
    logic [PW-1:0] mult [10];
    logic [9:1]    ge;
    logic [3:0]    digit;
    logic          advance, emit_digit, finish, load;

    always_comb begin
        pw      = i2a_pkg::pow10(r_pos);
        mult[0] = '0;
        ge      = '0;
        for (int d = 1; d <= 9; d++) begin
            mult[d] = pw * PW'(d);
            ge[d]   = ({2'b00, r_rem} >= mult[d]);
        end
        digit = 4'($countones(ge));
    end

    assign advance    = r_busy && !i_out_full;
    assign emit_digit = (digit != 4'd0) || r_started || (r_pos == 4'd0);
    assign finish     = advance && !r_sign && (r_pos == 4'd0);
    assign load       = !i_work_empty && (!r_busy || finish);
    assign o_work_pop = load;

    always_comb begin
        o_out_push         = 1'b0;
        o_char.ascii_char  = i2a_pkg::ASCII_ZERO + {4'd0, digit};
        o_char.is_last     = 1'b0;
        o_char.total_chars = 4'd0;
        if (advance) begin
            if (r_sign) begin
                o_out_push        = 1'b1;
                o_char.ascii_char = i2a_pkg::ASCII_MINUS;
            end else if (emit_digit) begin
                o_out_push = 1'b1;
                if (r_pos == 4'd0) begin
                    o_char.is_last     = 1'b1;
                    o_char.total_chars = r_cnt + 4'd1;
                end
            end
        end
    end

    always_comb begin
        n_busy    = r_busy;
        n_sign    = r_sign;
        n_started = r_started;
        n_pos     = r_pos;
        n_cnt     = r_cnt;
        n_rem     = r_rem;
        if (advance) begin
            if (r_sign) begin
                n_sign = 1'b0;
                n_cnt  = r_cnt + 4'd1;
            end else begin
                // Strip the digit at this position and move one place down
                n_rem = r_rem - mult[digit][31:0];
                if (emit_digit) begin
                    n_started = 1'b1;
                    n_cnt     = r_cnt + 4'd1;
                end
                if (r_pos == 4'd0) begin
                    n_busy = 1'b0;
                end else begin
                    n_pos = r_pos - 4'd1;
                end
            end
        end
        if (load) begin
            n_busy    = 1'b1;
            n_sign    = i_work.neg;
            n_started = 1'b0;
            n_pos     = i2a_pkg::TOP_POS;
            n_cnt     = 4'd0;
            n_rem     = i_work.mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_sign    <= 1'b0;
            r_started <= 1'b0;
            r_pos     <= 4'd0;
            r_cnt     <= 4'd0;
        end else begin
            r_busy    <= n_busy;
            r_sign    <= n_sign;
            r_started <= n_started;
            r_pos     <= n_pos;
            r_cnt     <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
    end

endmodule

`default_nettype wire

@@ hw/rtl/int32_to_decimal_ascii.sv @@
// Signed 32-bit integer to decimal ASCII text.
// Input side is a queue: drive i_value with i_push; the number is taken on a
// clock edge where i_push is high and o_full is low.
// Output side is a queue: while o_empty is low the oldest character sits on
// o_ascii_char / o_is_last / o_total_chars; it is taken when i_pop is high.
// Each number yields 1 to 11 characters, '-' first for negatives, no leading
// zeros. o_is_last marks the final character, which carries the count in
// o_total_chars (0 on all other characters).
// Each number passes through the work queue, the digit unit and the output queue
// before its first character reaches the outputs.
// The digit unit steps one decimal position per cycle while the output queue is
// not full, from 10^9 down to 10^0, after a step for the sign of a negative;
// it takes the next number in the same step as its last position.
// Reset (synchronous, i_rst_n low) empties both queues and idles the digit unit.
// When the receiver stalls, the output queue fills, the digit unit holds, and
// up to WORK_DEPTH further numbers are still taken before o_full rises.
`default_nettype none

module int32_to_decimal_ascii #(
    parameter int WORK_DEPTH = 2,
    parameter int OUT_DEPTH  = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire logic [31:0] i_value,
    output logic             o_full,
    input  wire logic        i_pop,
    output logic             o_empty,
    output logic [7:0]       o_ascii_char,
    output logic             o_is_last,
    output logic [3:0]       o_total_chars
);

    localparam int WORK_W = $bits(i2a_pkg::t_work);
    localparam int CHAR_W = $bits(i2a_pkg::t_char);

    i2a_pkg::t_work front_work, q_work;
    i2a_pkg::t_char back_char, q_char;
    logic           wq_push, wq_full, wq_empty, wq_pop;
    logic           oq_push, oq_full;

    i2a_front u_front (
        .i_value  (i_value),
        .i_push   (i_push),
        .i_q_full (wq_full),
        .o_q_push (wq_push),
        .o_work   (front_work),
        .o_full   (o_full)
    );

    i2a_fifo #(
        .WIDTH (WORK_W),
        .DEPTH (WORK_DEPTH)
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (wq_push),
        .i_data  (front_work),
        .o_full  (wq_full),
        .i_pop   (wq_pop),
        .o_data  (q_work),
        .o_empty (wq_empty)
    );

    i2a_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work       (q_work),
        .i_work_empty (wq_empty),
        .o_work_pop   (wq_pop),
        .i_out_full   (oq_full),
        .o_out_push   (oq_push),
        .o_char       (back_char)
    );

    i2a_fifo #(
        .WIDTH (CHAR_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (oq_push),
        .i_data  (back_char),
        .o_full  (oq_full),
        .i_pop   (i_pop),
        .o_data  (q_char),
        .o_empty (o_empty)
    );

    assign o_ascii_char  = q_char.ascii_char;
    assign o_is_last     = q_char.is_last;
    assign o_total_chars = q_char.total_chars;

    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        oq_push |-> (back_char.ascii_char == i2a_pkg::ASCII_MINUS) ||
                    ((back_char.ascii_char >= i2a_pkg::ASCII_ZERO) &&
                     (back_char.ascii_char <= (i2a_pkg::ASCII_ZERO + 8'd9))))
        else $error("illegal character produced");

    a_count_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (oq_push && !back_char.is_last) |-> (back_char.total_chars == 4'd0))
        else $error("count on a non-final character");

    a_last_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (oq_push && back_char.is_last) |->
            (back_char.total_chars >= 4'd1) && (back_char.total_chars <= 4'd11) &&
            (back_char.ascii_char != i2a_pkg::ASCII_MINUS))
        else $error("bad final character or count");

    a_stall_holds_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(q_char)))
        else $error("waiting character changed");

endmodule

`default_nettype wire
